[design/assert_macros.svh]
// Assertion helpers shared by the heap queue modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
        else $error("%m: assertion failed");

// Antecedent at an edge implies consequent at the same edge.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("%m: assertion failed");

`endif

[design/bmhq_pkg.sv]
package bmhq_pkg;

    localparam int DEF_CAPACITY  = 1024;
    localparam int DEF_KEY_WIDTH = 32;

    // Fixed field widths on the stream ports
    localparam int KEY_IO_W    = 32;
    localparam int STATUS_W    = 2;
    localparam int COUNT_IO_W  = 11;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 48;

    localparam logic MODE_INSERT  = 1'b0;
    localparam logic MODE_EXTRACT = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic                start_ins;  // load key, hole at count, count up
        logic                start_ext;  // read root and last, count down
        logic                ld_root;    // capture root as result, last as moving key
        logic                up_rd;      // read parent of hole
        logic                up_move;    // parent moves down into hole
        logic                dn_rd;      // read both children of hole
        logic                dn_move;    // smaller child moves up into hole
        logic                place;      // moving key settles in hole
        logic                res_set;    // new result: zero key, given status
        logic [STATUS_W-1:0] res_status;
        logic                out_load;   // copy result into output register
    } t_dp_cmd;

    typedef struct packed {
        logic full;
        logic empty;
        logic at_root;
        logic up_swap;
        logic has_left;
        logic dn_swap;
    } t_dp_stat;

endpackage

[design/bmhq_ctrl.sv]
`include "assert_macros.svh"

module bmhq_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_mode,
    input  logic               i_out_ready,
    input  bmhq_pkg::t_dp_stat i_stat,
    output logic               o_in_ready,
    output logic               o_out_valid,
    output bmhq_pkg::t_dp_cmd  o_cmd
);
    import bmhq_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_UP     = 3'd1;
    localparam logic [2:0] S_UP_CMP = 3'd2;
    localparam logic [2:0] S_EX_LD  = 3'd3;
    localparam logic [2:0] S_DN     = 3'd4;
    localparam logic [2:0] S_DN_CMP = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    logic [2:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       w_accept;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign w_accept    = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    o_cmd.res_set = 1'b1;
                    n_state       = S_DONE;
                    if (i_mode == MODE_INSERT) begin
                        if (i_stat.full) begin
                            o_cmd.res_status = ST_FULL;
                        end else begin
                            o_cmd.res_status = ST_OK;
                            o_cmd.start_ins  = 1'b1;
                            n_state          = S_UP;
                        end
                    end else begin
                        if (i_stat.empty) begin
                            o_cmd.res_status = ST_EMPTY;
                        end else begin
                            o_cmd.res_status = ST_OK;
                            o_cmd.start_ext  = 1'b1;
                            n_state          = S_EX_LD;
                        end
                    end
                end
            end
            S_UP: begin
                if (i_stat.at_root) begin
                    o_cmd.place = 1'b1;
                    n_state     = S_DONE;
                end else begin
                    o_cmd.up_rd = 1'b1;
                    n_state     = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                if (i_stat.up_swap) begin
                    o_cmd.up_move = 1'b1;
                    n_state       = S_UP;
                end else begin
                    o_cmd.place = 1'b1;
                    n_state     = S_DONE;
                end
            end
            S_EX_LD: begin
                o_cmd.ld_root = 1'b1;
                // the last key was the only one: nothing left to sift
                n_state = i_stat.empty ? S_DONE : S_DN;
            end
            S_DN: begin
                if (i_stat.has_left) begin
                    o_cmd.dn_rd = 1'b1;
                    n_state     = S_DN_CMP;
                end else begin
                    o_cmd.place = 1'b1;
                    n_state     = S_DONE;
                end
            end
            S_DN_CMP: begin
                if (i_stat.dn_swap) begin
                    o_cmd.dn_move = 1'b1;
                    n_state       = S_DN;
                end else begin
                    o_cmd.place = 1'b1;
                    n_state     = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    `ASSERT_IMPLY(a_up_cmp_from_up, i_clk, i_rst_n, r_state == S_UP_CMP, $past(r_state) == S_UP)
    `ASSERT_IMPLY(a_dn_cmp_from_dn, i_clk, i_rst_n, r_state == S_DN_CMP, $past(r_state) == S_DN)
    `ASSERT_IMPLY(a_load_when_free, i_clk, i_rst_n, o_cmd.out_load, !r_out_valid || i_out_ready)

endmodule

[design/bmhq_dp.sv]
`include "assert_macros.svh"

module bmhq_dp #(
    parameter int CAPACITY  = bmhq_pkg::DEF_CAPACITY,
    parameter int KEY_WIDTH = bmhq_pkg::DEF_KEY_WIDTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [bmhq_pkg::KEY_IO_W-1:0]       i_key,
    input  bmhq_pkg::t_dp_cmd                   i_cmd,
    output bmhq_pkg::t_dp_stat                  o_stat,
    output logic [bmhq_pkg::KEY_IO_W-1:0]       o_key_out,
    output logic [bmhq_pkg::STATUS_W-1:0]       o_status,
    output logic [bmhq_pkg::COUNT_IO_W-1:0]     o_count
);
    import bmhq_pkg::*;

    localparam int AW  = $clog2(CAPACITY);
    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int LW  = AW + 2;
    localparam int KWW = (KEY_WIDTH > KEY_IO_W) ? KEY_WIDTH : KEY_IO_W;
    localparam int CWW = (CW > COUNT_IO_W) ? CW : COUNT_IO_W;

    logic [KEY_WIDTH-1:0] r_mem [CAPACITY];
    logic [KEY_WIDTH-1:0] r_rd0, r_rd1;
    logic [KEY_WIDTH-1:0] r_key;
    logic [KEY_WIDTH-1:0] r_res_key;
    logic [STATUS_W-1:0]  r_res_status;
    logic [CW-1:0]        r_count;
    logic [AW-1:0]        r_pos;
    logic [KEY_IO_W-1:0]   r_out_key;
    logic [STATUS_W-1:0]   r_out_status;
    logic [COUNT_IO_W-1:0] r_out_count;

    logic [KWW-1:0]       w_key_wide;
    logic [KEY_WIDTH-1:0] w_key_in;
    logic [KWW-1:0]       w_res_wide;
    logic [CWW-1:0]       w_cnt_wide;
    logic [AW-1:0]        w_parent;
    logic [LW-1:0]        w_left, w_right;
    logic                 w_has_right;
    logic                 w_pick_right;
    logic [KEY_WIDTH-1:0] w_pick_val;
    logic [AW-1:0]        w_pick_idx;
    logic                 w_re;
    logic [AW-1:0]        w_ra0, w_ra1;
    logic                 w_we;
    logic [KEY_WIDTH-1:0] w_wdata;

    assign w_key_wide = KWW'(i_key);
    assign w_key_in   = w_key_wide[KEY_WIDTH-1:0];

    assign w_parent     = (r_pos - AW'(1)) >> 1;
    assign w_left       = {1'b0, r_pos, 1'b1};
    assign w_right      = w_left + LW'(1);
    assign w_has_right  = w_right < LW'(r_count);
    // tie between equal children goes left
    assign w_pick_right = w_has_right && (r_rd1 < r_rd0);
    assign w_pick_val   = w_pick_right ? r_rd1 : r_rd0;
    assign w_pick_idx   = w_pick_right ? w_right[AW-1:0] : w_left[AW-1:0];

    assign o_stat.full     = (r_count == CW'(CAPACITY));
    assign o_stat.empty    = (r_count == '0);
    assign o_stat.at_root  = (r_pos == '0);
    assign o_stat.up_swap  = r_key < r_rd0;
    assign o_stat.has_left = w_left < LW'(r_count);
    assign o_stat.dn_swap  = w_pick_val < r_key;

    // read port selection
    always_comb begin
        w_re  = i_cmd.up_rd || i_cmd.dn_rd || i_cmd.start_ext;
        w_ra0 = w_parent;
        w_ra1 = w_right[AW-1:0];
        if (i_cmd.start_ext) begin
            w_ra0 = '0;
            w_ra1 = AW'(r_count - CW'(1));
        end else if (i_cmd.dn_rd) begin
            w_ra0 = w_left[AW-1:0];
        end
    end

    // write port: the hole at r_pos is filled
    always_comb begin
        w_we    = i_cmd.up_move || i_cmd.dn_move || i_cmd.place;
        w_wdata = r_key;
        if (i_cmd.up_move) begin
            w_wdata = r_rd0;
        end else if (i_cmd.dn_move) begin
            w_wdata = w_pick_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[r_pos] <= w_wdata;
        end
        if (w_re) begin
            r_rd0 <= r_mem[w_ra0];
            r_rd1 <= r_mem[w_ra1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.start_ins) begin
            r_count <= r_count + CW'(1);
        end else if (i_cmd.start_ext) begin
            r_count <= r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start_ins) begin
            r_pos <= r_count[AW-1:0];
            r_key <= w_key_in;
        end else if (i_cmd.ld_root) begin
            r_pos <= '0;
            r_key <= r_rd1;
        end else if (i_cmd.up_move) begin
            r_pos <= w_parent;
        end else if (i_cmd.dn_move) begin
            r_pos <= w_pick_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_set) begin
            r_res_key    <= '0;
            r_res_status <= i_cmd.res_status;
        end else if (i_cmd.ld_root) begin
            r_res_key <= r_rd0;
        end
    end

    assign w_res_wide = KWW'(r_res_key);
    assign w_cnt_wide = CWW'(r_count);

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_key    <= w_res_wide[KEY_IO_W-1:0];
            r_out_status <= r_res_status;
            r_out_count  <= w_cnt_wide[COUNT_IO_W-1:0];
        end
    end

    assign o_key_out = r_out_key;
    assign o_status  = r_out_status;
    assign o_count   = r_out_count;

    `ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= CW'(CAPACITY))
    `ASSERT_ALWAYS(a_one_write, i_clk, i_rst_n, $onehot0({i_cmd.up_move, i_cmd.dn_move, i_cmd.place}))
    `ASSERT_IMPLY(a_ins_not_full, i_clk, i_rst_n, i_cmd.start_ins, r_count < CW'(CAPACITY))

endmodule

[design/binary_min_heap_queue_unit.sv]
// Bounded min-heap priority queue with stream ports.
// Input word (s_axis): tuser selects insert (tdata key stored) or extract of
// the smallest key. Output word (m_axis): one per input word; tdata carries the
// extracted key (zero on insert or error) and the key count after the
// operation, tuser a status (ok, full so insert dropped, empty so extract refused).
// Keys live in a two-read, one-write RAM as an implicit tree; the hole method
// moves one key per level instead of swapping.
// Timing: one operation at a time. Each sift-up level is a parent read, then a
// compare and write; each sift-down level reads both children together, then
// compares and writes. An extract first captures the root and the last key. A
// refused operation goes straight to the result. The input is ready again
// together with the result.
// The result sits in an output register, so the next word is accepted while
// the previous result waits; a stalled receiver holds the queue in its final
// step until the register frees up.
// Reset empties the queue; the RAM is not cleared (only slots below the
// count are ever used).
module binary_min_heap_queue_unit #(
    parameter int CAPACITY  = bmhq_pkg::DEF_CAPACITY,
    parameter int KEY_WIDTH = bmhq_pkg::DEF_KEY_WIDTH
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [31:0] key
    input  logic [bmhq_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // [0] mode
    input  logic                               s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [31:0] key_out, [42:32] count, rest zero
    output logic [bmhq_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    // [1:0] status
    output logic [bmhq_pkg::STATUS_W-1:0]      m_axis_tuser
);
    import bmhq_pkg::*;

    t_dp_cmd                w_cmd;
    t_dp_stat               w_stat;
    logic [KEY_IO_W-1:0]    w_key_out;
    logic [STATUS_W-1:0]    w_status;
    logic [COUNT_IO_W-1:0]  w_count;

    bmhq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_mode      (s_axis_tuser),
        .i_out_ready (m_axis_tready),
        .i_stat      (w_stat),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_cmd       (w_cmd)
    );

    bmhq_dp #(
        .CAPACITY  (CAPACITY),
        .KEY_WIDTH (KEY_WIDTH)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_key     (s_axis_tdata[KEY_IO_W-1:0]),
        .i_cmd     (w_cmd),
        .o_stat    (w_stat),
        .o_key_out (w_key_out),
        .o_status  (w_status),
        .o_count   (w_count)
    );

    assign m_axis_tdata = OUT_TDATA_W'({w_count, w_key_out});
    assign m_axis_tuser = w_status;

endmodule

[sim/testbench.sv]
`timescale 1ns / 100ps

module testbench;

    import bmhq_pkg::*;

    localparam int HEAP_CAP    = DEF_CAPACITY;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int TAIL_CYCLES = 40;

    typedef struct {
        logic        mode;
        logic [31:0] key;
        int          pace;   // 0: rx stalls more, 1: tx idles more, 2: no idling
    } t_heap_op;

    typedef struct {
        logic [KEY_IO_W-1:0]   key;
        logic [STATUS_W-1:0]   status;
        logic [COUNT_IO_W-1:0] count;
    } t_heap_result;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;   // [31:0] key
    logic                   s_axis_tuser = 1'b0; // [0] mode
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;        // [31:0] key, [42:32] count
    logic [STATUS_W-1:0]    m_axis_tuser;        // [1:0] status

    binary_min_heap_queue_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    t_heap_op     op_queue[$];
    t_heap_result heap_results_due[$];
    t_heap_op     cur_op;
    int           rx_pace = 0;
    int           gen_count = 0;
    int           errors = 0;
    int           cycles = 0;

    // shadow heap
    logic [31:0]  heap_keys[HEAP_CAP];
    int           heap_size = 0;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    task automatic flag_mismatch(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        errors++;
    endtask

    task automatic predict_heap_op(input t_heap_op op);
        t_heap_result r;
        int           pos;
        int           up;
        int           lc;
        int           pick;
        logic [31:0]  t;
        r.key    = '0;
        r.status = ST_OK;
        if (op.mode == MODE_INSERT) begin
            if (heap_size >= HEAP_CAP) begin
                r.status = ST_FULL;
            end else begin
                pos = heap_size;
                heap_keys[pos] = op.key;
                heap_size++;
                while (pos > 0) begin
                    up = (pos - 1) / 2;
                    if (heap_keys[pos] < heap_keys[up]) begin
                        t = heap_keys[pos];
                        heap_keys[pos] = heap_keys[up];
                        heap_keys[up] = t;
                        pos = up;
                    end else begin
                        break;
                    end
                end
            end
        end else begin
            if (heap_size == 0) begin
                r.status = ST_EMPTY;
            end else begin
                r.key = heap_keys[0];
                heap_size--;
                if (heap_size > 0) begin
                    heap_keys[0] = heap_keys[heap_size];
                    pos = 0;
                    forever begin
                        lc = 2 * pos + 1;
                        if (lc >= heap_size)
                            break;
                        // left child wins a tie
                        pick = lc;
                        if (lc + 1 < heap_size && heap_keys[lc + 1] < heap_keys[lc])
                            pick = lc + 1;
                        if (heap_keys[pick] < heap_keys[pos]) begin
                            t = heap_keys[pos];
                            heap_keys[pos] = heap_keys[pick];
                            heap_keys[pick] = t;
                            pos = pick;
                        end else begin
                            break;
                        end
                    end
                end
            end
        end
        r.count = heap_size[COUNT_IO_W-1:0];
        heap_results_due = {heap_results_due, r};
    endtask

    function automatic int tx_idle_pct(input int pace);
        return (pace == 0) ? 28 : (pace == 1) ? 58 : 0;
    endfunction

    function automatic int rx_idle_pct(input int pace);
        return (pace == 0) ? 58 : (pace == 1) ? 28 : 0;
    endfunction

    // mix of wide keys, tiny keys (lots of ties) and keys at both ends
    function automatic logic [31:0] rand_key();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $urandom_range(0, 15);
            2: return 32'hFFFF_FFF0 | $urandom_range(0, 15);
            default: begin
                case ($urandom_range(0, 3))
                    0: return 32'h0000_0000;
                    1: return 32'hFFFF_FFFF;
                    2: return 32'h8000_0000;
                    default: return 32'h7FFF_FFFF;
                endcase
            end
        endcase
    endfunction

    task automatic push_op(input logic mode, input logic [31:0] key, input int pace);
        t_heap_op op;
        op.mode = mode;
        op.key  = key;
        op.pace = pace;
        op_queue = {op_queue, op};
        if (mode == MODE_INSERT) begin
            if (gen_count < HEAP_CAP)
                gen_count++;
        end else if (gen_count > 0) begin
            gen_count--;
        end
    endtask

    // sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                predict_heap_op(cur_op);
            if (!s_axis_tvalid || s_axis_tready) begin
                if (op_queue.size() > 0 &&
                    $urandom_range(0, 99) >= tx_idle_pct(op_queue[0].pace)) begin
                    cur_op = op_queue.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= cur_op.key;
                    s_axis_tuser  <= cur_op.mode;
                    rx_pace       <= cur_op.pace;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver and checker
    always @(posedge i_clk) begin
        t_heap_result exp_r;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (heap_results_due.size() == 0) begin
                    flag_mismatch($sformatf("unexpected word %h/%h",
                                            m_axis_tdata, m_axis_tuser));
                end else begin
                    exp_r = heap_results_due.pop_front();
                    if (m_axis_tdata[31:0] !== exp_r.key)
                        flag_mismatch($sformatf("key_out %h, want %h",
                                                m_axis_tdata[31:0], exp_r.key));
                    if (m_axis_tuser !== exp_r.status)
                        flag_mismatch($sformatf("status %0d, want %0d",
                                                m_axis_tuser, exp_r.status));
                    if (m_axis_tdata[42:32] !== exp_r.count)
                        flag_mismatch($sformatf("count %0d, want %0d",
                                                m_axis_tdata[42:32], exp_r.count));
                end
            end
            m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct(rx_pace));
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            flag_mismatch($sformatf("timeout after %0d cycles, %0d words outstanding",
                                    cycles, heap_results_due.size()));
            $display("FAIL binary_min_heap_queue_unit");
            $finish;
        end
    end

    initial begin
        int ins_pct;

        // directed: empty extract, extremes, ties, full drain, extract past empty
        push_op(MODE_EXTRACT, 32'h0000_0000, 0);
        push_op(MODE_INSERT,  32'h0000_0000, 0);
        push_op(MODE_INSERT,  32'hFFFF_FFFF, 0);
        push_op(MODE_INSERT,  32'h0000_0005, 0);
        push_op(MODE_INSERT,  32'h0000_0005, 0);
        push_op(MODE_INSERT,  32'h0000_0005, 0);
        push_op(MODE_INSERT,  32'h0000_0003, 0);
        push_op(MODE_INSERT,  32'hFFFF_FFFF, 0);
        push_op(MODE_INSERT,  32'h0000_0000, 0);
        push_op(MODE_INSERT,  32'hAAAA_AAAA, 0);
        push_op(MODE_INSERT,  32'h5555_5555, 0);
        for (int i = 0; i < 10; i++)
            push_op(MODE_EXTRACT, 32'hFFFF_FFFF, 0);   // key field must be ignored
        push_op(MODE_EXTRACT, 32'h1234_5678, 0);
        push_op(MODE_EXTRACT, 32'h0000_0000, 0);

        // mixed traffic with drifting insert/extract balance, one block per pace
        for (int pace = 0; pace < 3; pace++) begin
            for (int seg = 0; seg < 2; seg++) begin
                ins_pct = $urandom_range(30, 80);
                for (int i = 0; i < 20; i++)
                    push_op(($urandom_range(0, 99) < ins_pct) ? MODE_INSERT : MODE_EXTRACT,
                            rand_key(), pace);
            end
        end

        // fill to capacity, hit the full case, churn near full, then forty extracts
        while (gen_count < HEAP_CAP)
            push_op(MODE_INSERT, rand_key(), 2);
        for (int i = 0; i < 6; i++)
            push_op(MODE_INSERT, rand_key(), 2);
        for (int i = 0; i < 20; i++)
            push_op($urandom_range(0, 1) ? MODE_INSERT : MODE_EXTRACT, rand_key(), 2);
        for (int i = 0; i < 40; i++)
            push_op(MODE_EXTRACT, rand_key(), 2);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (op_queue.size() > 0 || s_axis_tvalid || heap_results_due.size() > 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (errors == 0) begin
            $display("PASS binary_min_heap_queue_unit");
        end else begin
            $display("FAIL binary_min_heap_queue_unit");
        end
        $finish;
    end

endmodule
